// ===== rtl/nfsa_pkg.sv =====
`timescale 1ns / 1ps

package nfsa_pkg;

  localparam int SITES_DEF = 64;
  localparam int IDX_W     = 6;
  localparam int POS_W     = 16;
  localparam int CAP_W     = 16;
  localparam int DIST_W    = POS_W + 1;

  localparam logic [1:0] FUNC_LOAD   = 2'd0;
  localparam logic [1:0] FUNC_PLACE  = 2'd1;
  localparam logic [1:0] FUNC_REPORT = 2'd2;
  localparam logic [1:0] FUNC_CLEAR  = 2'd3;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_FULL    = 2'd1;
  localparam logic [1:0] STAT_NO_FREE = 2'd2;
  localparam logic [1:0] STAT_EMPTY   = 2'd3;

  typedef struct packed {
    logic [1:0]              func;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [CAP_W-1:0]        capacity;
  } nfsa_req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [IDX_W-1:0] site_index;
    logic [CAP_W-1:0] site_count;
    logic             last;
  } nfsa_rsp_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic [CAP_W-1:0]        cap;
    logic [CAP_W-1:0]        used;
  } nfsa_site_t;

  typedef struct packed {
    logic                    start;
    logic                    valid;
    logic [IDX_W-1:0]        idx;
    nfsa_site_t              site;
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
  } nfsa_pick_in_t;

  typedef struct packed {
    logic             found;
    logic             busy;
    logic [IDX_W-1:0] idx;
    nfsa_site_t       site;
  } nfsa_pick_res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT,
    ST_EMIT,
    ST_RPT_RD,
    ST_RPT_EMIT
  } nfsa_state_t;

endpackage

// ===== rtl/nfsa_pick.sv =====
`timescale 1ns / 1ps

module nfsa_pick (
  input  logic                    clk,
  input  logic                    rst_n,
  input  nfsa_pkg::nfsa_pick_in_t pick_in,
  output nfsa_pkg::nfsa_pick_res_t pick_res
);

  logic signed [nfsa_pkg::DIST_W-1:0] dx;
  logic signed [nfsa_pkg::DIST_W-1:0] dy;
  logic [nfsa_pkg::DIST_W-1:0]        adx;
  logic [nfsa_pkg::DIST_W-1:0]        ady;
  logic [nfsa_pkg::DIST_W-1:0]        man_dist;
  logic                               free;

  logic                               s2_v_r;
  logic                               s2_free_r;
  logic [nfsa_pkg::DIST_W-1:0]        s2_d_r;
  logic [nfsa_pkg::IDX_W-1:0]         s2_idx_r;
  nfsa_pkg::nfsa_site_t               s2_site_r;

  logic                               found_r;
  logic [nfsa_pkg::DIST_W-1:0]        best_d_r;
  logic [nfsa_pkg::IDX_W-1:0]         best_idx_r;
  nfsa_pkg::nfsa_site_t               best_site_r;
  logic                               better;

  // stage 1: Manhattan distance
  always_comb begin
    dx       = {pick_in.site.x[nfsa_pkg::POS_W-1], pick_in.site.x}
             - {pick_in.px[nfsa_pkg::POS_W-1], pick_in.px};
    dy       = {pick_in.site.y[nfsa_pkg::POS_W-1], pick_in.site.y}
             - {pick_in.py[nfsa_pkg::POS_W-1], pick_in.py};
    adx      = dx[nfsa_pkg::DIST_W-1] ? nfsa_pkg::DIST_W'(-dx) : nfsa_pkg::DIST_W'(dx);
    ady      = dy[nfsa_pkg::DIST_W-1] ? nfsa_pkg::DIST_W'(-dy) : nfsa_pkg::DIST_W'(dy);
    man_dist = adx + ady;
    free     = pick_in.site.used < pick_in.site.cap;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= pick_in.valid && !pick_in.start;
    end
  end

  always_ff @(posedge clk) begin
    s2_free_r <= free;
    s2_d_r    <= man_dist;
    s2_idx_r  <= pick_in.idx;
    s2_site_r <= pick_in.site;
  end

  // stage 2: running best; ties to lower x, lower y, then earlier index
  always_comb begin
    better = s2_free_r &&
             (!found_r || (s2_d_r < best_d_r) ||
              ((s2_d_r == best_d_r) &&
               (($signed(s2_site_r.x) < $signed(best_site_r.x)) ||
                (($signed(s2_site_r.x) == $signed(best_site_r.x)) &&
                 ($signed(s2_site_r.y) < $signed(best_site_r.y))))));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (pick_in.start) begin
      found_r <= 1'b0;
    end else if (s2_v_r && better) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!pick_in.start && s2_v_r && better) begin
      best_d_r    <= s2_d_r;
      best_idx_r  <= s2_idx_r;
      best_site_r <= s2_site_r;
    end
  end

  always_comb begin
    pick_res.found = found_r;
    pick_res.busy  = s2_v_r;
    pick_res.idx   = best_idx_r;
    pick_res.site  = best_site_r;
  end

endmodule

// ===== rtl/nearest_free_slot_allocator.sv =====
`timescale 1ns / 1ps
// Load, clear and requests on an empty table: result set in EXEC, then sent from EMIT.
// Place: scans the N loaded sites, one site memory read per cycle through a
// two-stage distance/compare pipeline, then DRAIN, COMMIT and EMIT.
// Report: one result per site, read in RPT_RD and sent in RPT_EMIT; waits while the output stalls.
// One request in flight; next request accepted once the result is queued.
// Synchronous reset empties the table by zeroing the fill count only.
module nearest_free_slot_allocator #(
  parameter int SITES = nfsa_pkg::SITES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  nfsa_pkg::nfsa_req_t in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output nfsa_pkg::nfsa_rsp_t out_data
);

  localparam int ADDR_W = (SITES > 1) ? $clog2(SITES) : 1;
  localparam int CNT_W  = $clog2(SITES + 1);

  nfsa_pkg::nfsa_state_t    state_r, state_nxt;
  nfsa_pkg::nfsa_req_t      req_r;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [ADDR_W-1:0]        scan_r, scan_nxt;
  nfsa_pkg::nfsa_rsp_t      res_r, res_nxt;
  logic                     out_valid_r, out_valid_nxt;
  nfsa_pkg::nfsa_rsp_t      out_data_r, out_data_nxt;

  nfsa_pkg::nfsa_site_t     site_mem [SITES];
  nfsa_pkg::nfsa_site_t     mem_q_r;
  logic                     rd_v_r;
  logic [ADDR_W-1:0]        rd_idx_r;

  logic                     mem_we;
  logic [ADDR_W-1:0]        mem_wa;
  nfsa_pkg::nfsa_site_t     mem_wd;
  logic                     rd_en;
  logic                     scan_rd;
  logic                     pick_start;
  logic                     out_free;
  logic                     scan_last;

  nfsa_pkg::nfsa_pick_in_t  pick_in;
  nfsa_pkg::nfsa_pick_res_t pick_res;

  assign in_stall  = (state_r != nfsa_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign scan_last = (CNT_W'(scan_r) == (cnt_r - CNT_W'(1)));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      nfsa_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = nfsa_pkg::ST_EXEC;
      end
      nfsa_pkg::ST_EXEC: begin
        case (req_r.func)
          nfsa_pkg::FUNC_PLACE: begin
            state_nxt = (cnt_r == '0) ? nfsa_pkg::ST_EMIT : nfsa_pkg::ST_SCAN;
          end
          nfsa_pkg::FUNC_REPORT: begin
            state_nxt = (cnt_r == '0) ? nfsa_pkg::ST_EMIT : nfsa_pkg::ST_RPT_RD;
          end
          default: state_nxt = nfsa_pkg::ST_EMIT;
        endcase
      end
      nfsa_pkg::ST_SCAN: begin
        if (scan_last) state_nxt = nfsa_pkg::ST_DRAIN;
      end
      nfsa_pkg::ST_DRAIN: begin
        if (!rd_v_r && !pick_res.busy) state_nxt = nfsa_pkg::ST_COMMIT;
      end
      nfsa_pkg::ST_COMMIT: state_nxt = nfsa_pkg::ST_EMIT;
      nfsa_pkg::ST_EMIT: begin
        if (out_free) state_nxt = nfsa_pkg::ST_IDLE;
      end
      nfsa_pkg::ST_RPT_RD: state_nxt = nfsa_pkg::ST_RPT_EMIT;
      nfsa_pkg::ST_RPT_EMIT: begin
        if (out_free) begin
          state_nxt = scan_last ? nfsa_pkg::ST_IDLE : nfsa_pkg::ST_RPT_RD;
        end
      end
      default: state_nxt = nfsa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    mem_we        = 1'b0;
    mem_wa        = cnt_r[ADDR_W-1:0];
    mem_wd        = mem_q_r;
    rd_en         = 1'b0;
    scan_rd       = 1'b0;
    pick_start    = 1'b0;
    cnt_nxt       = cnt_r;
    scan_nxt      = scan_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    case (state_r)
      nfsa_pkg::ST_EXEC: begin
        scan_nxt           = '0;
        pick_start         = 1'b1;
        res_nxt.status     = nfsa_pkg::STAT_OK;
        res_nxt.site_index = '0;
        res_nxt.site_count = '0;
        res_nxt.last       = 1'b1;
        case (req_r.func)
          nfsa_pkg::FUNC_LOAD: begin
            if (cnt_r == CNT_W'(SITES)) begin
              res_nxt.status = nfsa_pkg::STAT_FULL;
            end else begin
              mem_we             = 1'b1;
              mem_wd.x           = req_r.pos_x;
              mem_wd.y           = req_r.pos_y;
              mem_wd.cap         = req_r.capacity;
              mem_wd.used        = '0;
              cnt_nxt            = cnt_r + CNT_W'(1);
              res_nxt.site_index = nfsa_pkg::IDX_W'(cnt_r);
            end
          end
          nfsa_pkg::FUNC_CLEAR: cnt_nxt = '0;
          default: begin
            if (cnt_r == '0) res_nxt.status = nfsa_pkg::STAT_EMPTY;
          end
        endcase
      end
      nfsa_pkg::ST_SCAN: begin
        rd_en    = 1'b1;
        scan_rd  = 1'b1;
        scan_nxt = scan_r + ADDR_W'(1);
      end
      nfsa_pkg::ST_COMMIT: begin
        res_nxt.last = 1'b1;
        if (pick_res.found) begin
          mem_we             = 1'b1;
          mem_wa             = ADDR_W'(pick_res.idx);
          mem_wd             = pick_res.site;
          mem_wd.used        = pick_res.site.used + nfsa_pkg::CAP_W'(1);
          res_nxt.status     = nfsa_pkg::STAT_OK;
          res_nxt.site_index = pick_res.idx;
          res_nxt.site_count = pick_res.site.used + nfsa_pkg::CAP_W'(1);
        end else begin
          res_nxt.status     = nfsa_pkg::STAT_NO_FREE;
          res_nxt.site_index = '0;
          res_nxt.site_count = '0;
        end
      end
      nfsa_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
        end
      end
      nfsa_pkg::ST_RPT_RD: rd_en = 1'b1;
      nfsa_pkg::ST_RPT_EMIT: begin
        if (out_free) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.status     = nfsa_pkg::STAT_OK;
          out_data_nxt.site_index = nfsa_pkg::IDX_W'(scan_r);
          out_data_nxt.site_count = mem_q_r.used;
          out_data_nxt.last       = scan_last;
          scan_nxt                = scan_r + ADDR_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nfsa_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      rd_v_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      rd_v_r      <= scan_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == nfsa_pkg::ST_IDLE && in_valid) req_r <= in_data;
    scan_r     <= scan_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
    rd_idx_r   <= scan_r;
  end

  always_ff @(posedge clk) begin
    if (mem_we) site_mem[mem_wa] <= mem_wd;
    if (rd_en) mem_q_r <= site_mem[scan_r];
  end

  always_comb begin
    pick_in.start = pick_start;
    pick_in.valid = rd_v_r;
    pick_in.idx   = nfsa_pkg::IDX_W'(rd_idx_r);
    pick_in.site  = mem_q_r;
    pick_in.px    = req_r.pos_x;
    pick_in.py    = req_r.pos_y;
  end

  nfsa_pick u_pick (
    .clk      (clk),
    .rst_n    (rst_n),
    .pick_in  (pick_in),
    .pick_res (pick_res)
  );

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(SITES))
    else $error("fill count above table size");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == nfsa_pkg::ST_SCAN || state_r == nfsa_pkg::ST_DRAIN) |-> !mem_we)
    else $error("table written during scan");

  a_rd_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rd_v_r |-> $past(state_r) == nfsa_pkg::ST_SCAN)
    else $error("scan data valid without scan read");

  a_commit_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == nfsa_pkg::ST_COMMIT && pick_res.found) |->
      (pick_res.site.used < pick_res.site.cap))
    else $error("full site chosen");

  a_commit_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == nfsa_pkg::ST_COMMIT && pick_res.found) |->
      (nfsa_pkg::IDX_W'(cnt_r) > pick_res.idx || cnt_r == CNT_W'(SITES)))
    else $error("chosen site beyond loaded range");

endmodule
